[rtl/core/lpi_pkg.sv]
// Package for the line pixel interpolator: widths, pipeline depths and the
// structs that travel between the front end, the dividers and the top level.
// No dependencies.
package lpi_pkg;

    localparam int COORD_BITS  = 10;
    localparam int COLOUR_BITS = 24;
    localparam int ARGB_BITS   = 32;
    localparam logic [ARGB_BITS-COLOUR_BITS-1:0] ALPHA_OPAQUE = '1;

    localparam int DIFF_BITS = COORD_BITS + 1;
    localparam int PROD_BITS = 2 * COORD_BITS;
    localparam int DEN_BITS  = COORD_BITS + 1;

    // Quotient bits resolved per divider stage.
    localparam int QSTEP      = 2;
    localparam int DIV_STAGES = (COORD_BITS + QSTEP - 1) / QSTEP;
    localparam int Q_BITS     = DIV_STAGES * QSTEP;
    localparam int REM_BITS   = DEN_BITS + Q_BITS + 1;

    localparam int FRONT_STAGES = 3;
    localparam int PIPE_STAGES  = FRONT_STAGES + DIV_STAGES + 1;

    typedef logic [COORD_BITS-1:0] coord_t;

    // Per-word data that is not touched by the dividers.
    typedef struct packed {
        logic                   pix_valid;
        logic                   last;
        coord_t                 steps;
        logic [COLOUR_BITS-1:0] colour;
    } side_t;

    // One axis in flight through the divider.
    typedef struct packed {
        coord_t              start;
        logic                neg;
        logic [REM_BITS-1:0] rem;
        logic [DEN_BITS-1:0] den;
        logic [Q_BITS-1:0]   quo;
    } divw_t;

endpackage

[rtl/core/lpi_front.sv]
// Front end of the line pixel interpolator: deltas and step count, the
// magnitude products, and the rounded dividend and divisor. Uses lpi_pkg.
module lpi_front
    import lpi_pkg::*;
(
    input  logic                    clk,
    input  logic [FRONT_STAGES-1:0] en,
    input  coord_t                  start_x,
    input  coord_t                  start_y,
    input  coord_t                  end_x,
    input  coord_t                  end_y,
    input  coord_t                  step_index,
    input  logic [COLOUR_BITS-1:0]  rgb_colour,
    output divw_t                   div_x,
    output divw_t                   div_y,
    output side_t                   side
);

    // Stage A: absolute deltas, signs and step count.
    logic [DIFF_BITS-1:0] dx, dy;
    coord_t adx_next, ady_next, steps_a_next;
    coord_t adx_reg, ady_reg, steps_a_reg, sx_a_reg, sy_a_reg, idx_a_reg;
    logic   negx_a_reg, negy_a_reg;
    logic [COLOUR_BITS-1:0] colour_a_reg;

    always_comb
    begin
        dx = {1'b0, end_x} - {1'b0, start_x};
        dy = {1'b0, end_y} - {1'b0, start_y};
        adx_next = dx[DIFF_BITS-1] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
        ady_next = dy[DIFF_BITS-1] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
        steps_a_next = (adx_next > ady_next) ? adx_next : ady_next;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            adx_reg      <= adx_next;
            ady_reg      <= ady_next;
            negx_a_reg   <= dx[DIFF_BITS-1];
            negy_a_reg   <= dy[DIFF_BITS-1];
            steps_a_reg  <= steps_a_next;
            sx_a_reg     <= start_x;
            sy_a_reg     <= start_y;
            idx_a_reg    <= step_index;
            colour_a_reg <= rgb_colour;
        end
    end

    // Stage B: products and the step flags.
    logic [PROD_BITS-1:0] prod_x_reg, prod_y_reg;
    coord_t steps_b_reg, sx_b_reg, sy_b_reg;
    logic   negx_b_reg, negy_b_reg;
    side_t  side_b_next, side_b_reg;

    always_comb
    begin
        side_b_next.pix_valid = (steps_a_reg != '0) && (idx_a_reg < steps_a_reg);
        side_b_next.last      = side_b_next.pix_valid
                                && (idx_a_reg == steps_a_reg - COORD_BITS'(1));
        side_b_next.steps     = steps_a_reg;
        side_b_next.colour    = colour_a_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            prod_x_reg  <= adx_reg * idx_a_reg;
            prod_y_reg  <= ady_reg * idx_a_reg;
            steps_b_reg <= steps_a_reg;
            sx_b_reg    <= sx_a_reg;
            sy_b_reg    <= sy_a_reg;
            negx_b_reg  <= negx_a_reg;
            negy_b_reg  <= negy_a_reg;
            side_b_reg  <= side_b_next;
        end
    end

    // Stage C: dividend 2*|d|*i + steps, less one for a negative delta so that
    // the floor of the unsigned quotient gives round-half-up after negation.
    divw_t div_x_next, div_y_next, div_x_reg, div_y_reg;
    side_t side_c_reg;

    always_comb
    begin
        div_x_next.start = sx_b_reg;
        div_x_next.neg   = negx_b_reg;
        div_x_next.rem   = REM_BITS'({prod_x_reg, 1'b0}) + REM_BITS'(steps_b_reg)
                           - REM_BITS'(negx_b_reg);
        div_x_next.den   = {steps_b_reg, 1'b0};
        div_x_next.quo   = '0;
        div_y_next.start = sy_b_reg;
        div_y_next.neg   = negy_b_reg;
        div_y_next.rem   = REM_BITS'({prod_y_reg, 1'b0}) + REM_BITS'(steps_b_reg)
                           - REM_BITS'(negy_b_reg);
        div_y_next.den   = {steps_b_reg, 1'b0};
        div_y_next.quo   = '0;
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            div_x_reg  <= div_x_next;
            div_y_reg  <= div_y_next;
            side_c_reg <= side_b_reg;
        end
    end

    assign div_x = div_x_reg;
    assign div_y = div_y_reg;
    assign side  = side_c_reg;

endmodule

[rtl/core/lpi_div.sv]
// Pipelined restoring divider for one axis, QSTEP quotient bits per stage.
// Uses lpi_pkg.
module lpi_div
    import lpi_pkg::*;
(
    input  logic                  clk,
    input  logic [DIV_STAGES-1:0] en,
    input  divw_t                 din,
    output divw_t                 dout
);

    divw_t stage_reg [DIV_STAGES];

    for (genvar s = 0; s < DIV_STAGES; s++)
    begin : g_stage
        divw_t               cur;
        divw_t               stage_in;
        logic [REM_BITS-1:0] trial;

        if (s == 0)
        begin : g_first
            assign stage_in = din;
        end
        else
        begin : g_rest
            assign stage_in = stage_reg[s-1];
        end

        always_comb
        begin
            cur   = stage_in;
            trial = '0;
            for (int j = 0; j < QSTEP; j++)
            begin
                trial = REM_BITS'(cur.den) << (Q_BITS - 1 - (s * QSTEP + j));
                if (cur.rem >= trial)
                begin
                    cur.rem = cur.rem - trial;
                    cur.quo[Q_BITS - 1 - (s * QSTEP + j)] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[s])
            begin
                stage_reg[s] <= cur;
            end
        end
    end

    assign dout = stage_reg[DIV_STAGES-1];

endmodule

[rtl/core/line_pixel_interpolator_top.sv]
// Top level of the line pixel interpolator: handshake control, the sideband
// pipeline and the output register. Uses lpi_pkg, lpi_front and lpi_div.
//
// Usage: each input word holds a line's endpoints, a step index and a 24-bit
// color. The block returns one output word per input word: the pixel at that
// step of the DDA line, rounded half up, the packed opaque ARGB color, the
// step count max(|dx|, |dy|), a pixel_valid flag (step index below the step
// count) and is_last (the final drawn step). The end point itself is never
// produced; a zero-length line gives pixel_valid low. When pixel_valid is low,
// pixel_x and pixel_y are zero.
// Both channels use valid/ready; a word moves when valid and ready are high.
// The pipeline has three front stages (deltas, products, dividend), one stage
// per two quotient bits of the divider, and the output register. Throughput is
// one word per clock while the receiver holds out_ready high; the divider
// pipeline is what sets the depth.
// Each stage advances when it is empty or its successor advances, so bubbles
// are squeezed out while the receiver stalls, and in_ready only drops once
// every stage holds a word. Reset clears all stage valid bits; the data
// registers are not reset.
module line_pixel_interpolator_top
    import lpi_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  coord_t                 start_x,
    input  coord_t                 start_y,
    input  coord_t                 end_x,
    input  coord_t                 end_y,
    input  coord_t                 step_index,
    input  logic [COLOUR_BITS-1:0] rgb_colour,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   pixel_valid,
    output coord_t                 pixel_x,
    output coord_t                 pixel_y,
    output logic [ARGB_BITS-1:0]   pixel_argb,
    output logic                   is_last,
    output coord_t                 step_count
);

    // Stage valid bits and the advance chain, from the output backwards.
    logic [PIPE_STAGES-1:0] vld_reg, vld_next, en;

    always_comb
    begin
        en[PIPE_STAGES-1] = !vld_reg[PIPE_STAGES-1] || out_ready;
        for (int k = PIPE_STAGES - 2; k >= 0; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
        for (int k = 0; k < PIPE_STAGES; k++)
        begin
            if (en[k])
            begin
                vld_next[k] = (k == 0) ? in_valid : vld_reg[(k == 0) ? 0 : k - 1];
            end
            else
            begin
                vld_next[k] = vld_reg[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign in_ready  = en[0];
    assign out_valid = vld_reg[PIPE_STAGES-1];

    // Front end: deltas, products and dividends.
    divw_t front_x, front_y;
    side_t front_side;

    lpi_front u_front
    (
        .clk        (clk),
        .en         (en[FRONT_STAGES-1:0]),
        .start_x    (start_x),
        .start_y    (start_y),
        .end_x      (end_x),
        .end_y      (end_y),
        .step_index (step_index),
        .rgb_colour (rgb_colour),
        .div_x      (front_x),
        .div_y      (front_y),
        .side       (front_side)
    );

    // One divider per axis, in lockstep.
    divw_t quo_x, quo_y;

    lpi_div u_div_x
    (
        .clk  (clk),
        .en   (en[FRONT_STAGES +: DIV_STAGES]),
        .din  (front_x),
        .dout (quo_x)
    );

    lpi_div u_div_y
    (
        .clk  (clk),
        .en   (en[FRONT_STAGES +: DIV_STAGES]),
        .din  (front_y),
        .dout (quo_y)
    );

    // Sideband travels beside the dividers.
    side_t side_reg [DIV_STAGES];

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < DIV_STAGES; s++)
        begin
            if (en[FRONT_STAGES + s])
            begin
                side_reg[s] <= (s == 0) ? front_side : side_reg[(s == 0) ? 0 : s - 1];
            end
        end
    end

    // Output stage: apply the sign, add the start point, zero invalid pixels.
    side_t  side_out;
    coord_t off_x, off_y, px_next, py_next;
    coord_t px_reg, py_reg, steps_reg;
    logic   pv_reg, last_reg;
    logic [COLOUR_BITS-1:0] colour_reg;

    always_comb
    begin
        side_out = side_reg[DIV_STAGES-1];
        off_x    = quo_x.quo[COORD_BITS-1:0];
        off_y    = quo_y.quo[COORD_BITS-1:0];
        px_next  = quo_x.neg ? quo_x.start - off_x : quo_x.start + off_x;
        py_next  = quo_y.neg ? quo_y.start - off_y : quo_y.start + off_y;
        if (!side_out.pix_valid)
        begin
            px_next = '0;
            py_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[PIPE_STAGES-1])
        begin
            px_reg     <= px_next;
            py_reg     <= py_next;
            pv_reg     <= side_out.pix_valid;
            last_reg   <= side_out.last;
            steps_reg  <= side_out.steps;
            colour_reg <= side_out.colour;
        end
    end

    assign pixel_valid = pv_reg;
    assign pixel_x     = px_reg;
    assign pixel_y     = py_reg;
    assign pixel_argb  = {ALPHA_OPAQUE, colour_reg};
    assign is_last     = last_reg;
    assign step_count  = steps_reg;

    // An empty output register means every stage can advance.
    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled while the output stage is empty");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !pixel_valid) |-> (pixel_x == '0 && pixel_y == '0))
        else $error("invalid pixel carries a nonzero position");

    a_last_is_drawn: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && is_last) |-> (pixel_valid && step_count != '0))
        else $error("last flag on a pixel that is not drawn");

    a_drawn_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && pixel_valid) |-> (step_count != '0))
        else $error("pixel drawn on a zero-length line");

endmodule

[tb/lpi_pixel_checker.sv]
// Checker for the line pixel interpolator: watches both channels, predicts each pixel
// word from the accepted line word and compares it field by field.
// Depends on lpi_pkg for the coordinate type and widths.
module lpi_pixel_checker
    import lpi_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   in_ready,
    input  coord_t                 start_x,
    input  coord_t                 start_y,
    input  coord_t                 end_x,
    input  coord_t                 end_y,
    input  coord_t                 step_index,
    input  logic [COLOUR_BITS-1:0] rgb_colour,
    input  logic                   out_valid,
    input  logic                   out_ready,
    input  logic                   pixel_valid,
    input  coord_t                 pixel_x,
    input  coord_t                 pixel_y,
    input  logic [ARGB_BITS-1:0]   pixel_argb,
    input  logic                   is_last,
    input  coord_t                 step_count,
    output int                     words_pending,
    output int                     error_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                 pix_valid;
        coord_t               x;
        coord_t               y;
        logic [ARGB_BITS-1:0] argb;
        logic                 last;
        coord_t               steps;
    } pixel_t;

    pixel_t expected_pixels[$];

    initial
    begin
        words_pending = 0;
        error_count   = 0;
    end

    // Offset d*i/span rounded half up, i.e. floor((2*d*i + span) / (2*span)).
    function automatic int round_half_up_ratio(input int d, input int i, input int span);
        int num;
        int den;
        num = 2 * d * i + span;
        den = 2 * span;
        if (num >= 0)
            return num / den;
        return -((-num + den - 1) / den);
    endfunction

    function automatic pixel_t predict_pixel(input coord_t sx, input coord_t sy,
                                             input coord_t ex, input coord_t ey,
                                             input coord_t idx,
                                             input logic [COLOUR_BITS-1:0] colour);
        int     dx;
        int     dy;
        int     span;
        pixel_t p;
        dx   = int'(ex) - int'(sx);
        dy   = int'(ey) - int'(sy);
        span = (dx < 0) ? -dx : dx;
        if (((dy < 0) ? -dy : dy) > span)
            span = (dy < 0) ? -dy : dy;
        p.pix_valid = (span > 0) && (int'(idx) < span);
        p.x     = p.pix_valid
                  ? coord_t'(int'(sx) + round_half_up_ratio(dx, int'(idx), span)) : '0;
        p.y     = p.pix_valid
                  ? coord_t'(int'(sy) + round_half_up_ratio(dy, int'(idx), span)) : '0;
        p.argb  = {ALPHA_OPAQUE, colour};
        p.last  = p.pix_valid && (int'(idx) == span - 1);
        p.steps = coord_t'(span);
        return p;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin : monitor
        pixel_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    $error("pixel word with no line word outstanding");
                    error_count++;
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    check_field("pixel_valid", 32'(want.pix_valid), 32'(pixel_valid));
                    check_field("pixel_x", 32'(want.x), 32'(pixel_x));
                    check_field("pixel_y", 32'(want.y), 32'(pixel_y));
                    check_field("pixel_argb", want.argb, pixel_argb);
                    check_field("is_last", 32'(want.last), 32'(is_last));
                    check_field("step_count", 32'(want.steps), 32'(step_count));
                end
            end
            if (in_valid && in_ready)
                expected_pixels.insert(expected_pixels.size(),
                                       predict_pixel(start_x, start_y, end_x, end_y,
                                                     step_index, rgb_colour));
            words_pending <= expected_pixels.size();
        end
    end

endmodule

[tb/tb_line_pixel_interpolator_top.sv]
// Testbench top for the line pixel interpolator: clock, reset, line word stimulus
// and the pixel receiver. Depends on lpi_pkg, line_pixel_interpolator_top and
// lpi_pixel_checker, which does all prediction and comparison.
module tb_line_pixel_interpolator_top;
    import lpi_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_MAX    = (1 << COORD_BITS) - 1;
    localparam int RANDOM_WORDS = 500;
    localparam int IDLE_PERCENT = 27;
    // Cycles the receiver refuses pixel words in one go; far more than the pipeline depth,
    // so every stage fills and in_ready has to drop.
    localparam int HOLD_OFF_CYCLES = 60;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    coord_t                 start_x;
    coord_t                 start_y;
    coord_t                 end_x;
    coord_t                 end_y;
    coord_t                 step_index;
    logic [COLOUR_BITS-1:0] rgb_colour;
    logic                   out_valid;
    logic                   out_ready;
    logic                   pixel_valid;
    coord_t                 pixel_x;
    coord_t                 pixel_y;
    logic [ARGB_BITS-1:0]   pixel_argb;
    logic                   is_last;
    coord_t                 step_count;

    int words_pending;
    int error_count;

    // Shared between the sender and the receiver: calm turns idling off on both sides,
    // hold_off_req asks the receiver for one long stall.
    bit calm;
    bit hold_off_req;
    bit hold_off_done;

    line_pixel_interpolator_top u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .start_x    (start_x),
        .start_y    (start_y),
        .end_x      (end_x),
        .end_y      (end_y),
        .step_index (step_index),
        .rgb_colour (rgb_colour),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .pixel_valid(pixel_valid),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .pixel_argb (pixel_argb),
        .is_last    (is_last),
        .step_count (step_count)
    );

    lpi_pixel_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .start_x      (start_x),
        .start_y      (start_y),
        .end_x        (end_x),
        .end_y        (end_y),
        .step_index   (step_index),
        .rgb_colour   (rgb_colour),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pixel_valid  (pixel_valid),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .pixel_argb   (pixel_argb),
        .is_last      (is_last),
        .step_count   (step_count),
        .words_pending(words_pending),
        .error_count  (error_count)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    // Offers one line word. Before it, the sender may go quiet, each cycle idle
    // with the same chance, so gaps land at every point of the
    // pipeline's work. The task returns in the time step of the edge at which the word
    // was accepted; in_ready is read right after the edge and so holds its value from
    // before it.
    task automatic send_word(input coord_t sx, input coord_t sy, input coord_t ex,
                             input coord_t ey, input coord_t idx,
                             input logic [COLOUR_BITS-1:0] colour);
        if (!calm)
        begin
            while ($urandom_range(99) < IDLE_PERCENT)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid   <= 1'b1;
        start_x    <= sx;
        start_y    <= sy;
        end_x      <= ex;
        end_y      <= ey;
        step_index <= idx;
        rgb_colour <= colour;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Lowers valid and waits until every pixel word owed has come back. The extra edge
    // first lets the checker count the word accepted at this very edge.
    task automatic drain_pipeline();
        in_valid <= 1'b0;
        @(posedge clk);
        wait (words_pending == 0);
        @(posedge clk);
    endtask

    // Receiver. It stalls at random, never during the calm stretch, and once holds
    // off for a long run of cycles while the sender keeps offering words.
    initial
    begin
        out_ready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off_req && !hold_off_done)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_done = 1'b1;
            end
            else
            begin
                out_ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
            end
        end
    end

    // Stimulus and verdict.
    initial
    begin
        int sx;
        int sy;
        int ex;
        int ey;
        int idx;
        int span;
        int kind;
        int pick;

        in_valid   = 1'b0;
        start_x    = '0;
        start_y    = '0;
        end_x      = '0;
        end_y      = '0;
        step_index = '0;
        rgb_colour = '0;
        calm          = 1'b0;
        hold_off_req  = 1'b0;
        hold_off_done = 1'b0;
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words. Zero-length lines at both corners of the coordinate range.
        send_word(0, 0, 0, 0, 0, 24'h000000);
        send_word(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 24'hFFFFFF);
        // The longest diagonal, its first step and its last drawn step.
        send_word(0, 0, COORD_MAX, COORD_MAX, 0, 24'hAAAAAA);
        send_word(0, 0, COORD_MAX, COORD_MAX, COORD_MAX - 1, 24'h555555);
        // A horizontal line: the last drawn step, then the end point, which is never drawn.
        send_word(0, 5, COORD_MAX, 5, COORD_MAX - 1, 24'h123456);
        send_word(0, 5, COORD_MAX, 5, COORD_MAX, 24'hFEDCBA);
        // Both deltas negative, from the far corner back to the origin.
        send_word(COORD_MAX, COORD_MAX, 0, 0, 511, 24'h0F0F0F);
        send_word(COORD_MAX, COORD_MAX, 0, 0, 512, 24'hF0F0F0);
        // Steep lines, where y sets the step count, going down and up.
        send_word(10, 0, 13, COORD_MAX, 700, 24'h800000);
        send_word(100, 900, 90, 0, 450, 24'h008000);
        // Exact halves: a positive half rounds up, a negative half rounds toward zero.
        send_word(0, 0, 1, 2, 1, 24'h000080);
        send_word(5, 5, 4, 3, 1, 24'h7F7F7F);
        // A one-step line, whose only drawn step is also the last.
        send_word(7, 7, 8, 7, 0, 24'h808080);
        // A short line: last drawn step, one past it, and a step index far past it.
        send_word(3, 3, 0, 6, 2, 24'h010203);
        send_word(3, 3, 0, 6, 3, 24'h040506);
        send_word(0, 0, 3, 3, COORD_MAX, 24'h070809);
        // x alone sets the step count, from the right edge back to the left.
        send_word(COORD_MAX, 0, 0, 0, COORD_MAX, 24'hFF0000);
        send_word(COORD_MAX, 0, 0, 0, COORD_MAX - 1, 24'h00FF00);
        send_word(COORD_MAX, 0, 0, 1, 1, 24'h0000FF);

        // Random words. Most are steps that lie on a line, a share are lines only a few
        // pixels long so that rounding shows, and the rest are zero-length lines and
        // step indexes anywhere in range.
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            // The sender pauses until every pixel word is home, here and once more later.
            if (n == 0 || n == 350)
                drain_pipeline();
            calm = (n >= 200 && n < 300);
            if (n == 120)
                hold_off_req = 1'b1;

            kind = $urandom_range(99);
            pick = $urandom_range(9);
            sx = $urandom_range(COORD_MAX);
            sy = $urandom_range(COORD_MAX);
            if (kind < 8)
            begin
                ex = sx;
                ey = sy;
            end
            else if (kind < 35)
            begin
                ex = sx + int'($urandom_range(16)) - 8;
                ey = sy + int'($urandom_range(16)) - 8;
            end
            else
            begin
                ex = $urandom_range(COORD_MAX);
                ey = $urandom_range(COORD_MAX);
            end
            ex = (ex < 0) ? 0 : ((ex > COORD_MAX) ? COORD_MAX : ex);
            ey = (ey < 0) ? 0 : ((ey > COORD_MAX) ? COORD_MAX : ey);

            span = (ex > sx) ? ex - sx : sx - ex;
            if (((ey > sy) ? ey - sy : sy - ey) > span)
                span = (ey > sy) ? ey - sy : sy - ey;

            if (span > 0 && pick < 7)
                idx = $urandom_range(span - 1);
            else if (span > 0 && pick < 8)
                idx = span - 1;
            else
                idx = $urandom_range(COORD_MAX);

            send_word(coord_t'(sx), coord_t'(sy), coord_t'(ex), coord_t'(ey),
                      coord_t'(idx), COLOUR_BITS'($urandom_range(24'hFFFFFF)));
        end

        // Wait for the last pixel word, then a little longer than the pipeline depth so
        // that a stray extra word would still be caught by the checker.
        drain_pipeline();
        repeat (PIPE_STAGES + 4) @(posedge clk);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Watchdog: a correct run ends in well under a tenth of this time.
    initial
    begin
        #1000000;
        $display("Some tests failed");
        $finish;
    end

endmodule
